### rtl/bfm_pkg.sv
// shared types and constants for the box filter mean core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bfm_pkg;

  localparam int MAX_RADIUS_DEF = 7;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT     = 4096;

  // radius register is 3 bits, so the window is at most 15 by 15
  localparam int RAD_W  = 3;
  localparam int AREA_W = 8;
  localparam int SUM_W  = AREA_W + 8;
  localparam int QUO_W  = 8;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SUM,
    S_FLUSH,
    S_PUSH,
    S_WAIT,
    S_HOLD
  } state_e;

endpackage

`default_nettype wire

### rtl/bfm_div_cell.sv
// one restoring division step of the mean divider chain
// depends on bfm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfm_div_cell
  import bfm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire logic [AREA_W-1:0] rem_i,
  input  wire logic [7:0]        low_i,
  input  wire logic [QUO_W-1:0]  quo_i,
  input  wire logic [AREA_W-1:0] area_i,
  output logic                   vld_o,
  output logic [AREA_W-1:0]      rem_o,
  output logic [7:0]             low_o,
  output logic [QUO_W-1:0]       quo_o
);

  logic [AREA_W:0]   trial;
  logic              ge;
  logic              vld_q;
  logic [AREA_W-1:0] rem_q, rem_d;
  logic [7:0]        low_q;
  logic [QUO_W-1:0]  quo_q;

  always_comb begin
    trial = {rem_i, low_i[7]};
    ge    = (trial >= {1'b0, area_i});
    rem_d = ge ? AREA_W'(trial - {1'b0, area_i}) : trial[AREA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= {low_i[6:0], 1'b0};
    quo_q <= {quo_i[QUO_W-2:0], ge};
  end

  assign vld_o = vld_q;
  assign rem_o = rem_q;
  assign low_o = low_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

### rtl/bfm_row_store.sv
// ring of pixel rows, one write and one registered read per cycle
// depends on bfm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfm_row_store
  import bfm_pkg::*;
#(
  parameter int ADDR_W = 14
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]             rdata_o
);

  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/box_filter_mean_core.sv
// box filter mean: window sum read from a row ring, mean from a chain of divider cells
// sequence: an item that releases no output is checked and the core returns to idle; one
// that releases an output waits for the one-read-per-cycle window sweep of the row store,
// then 8 divider cells, then a free output slot; one item is in work at a time
// reset clears the control state and positions; the row store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module box_filter_mean_core
  import bfm_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] pixel
  input  wire logic        s_axis_tuser_i,   // [0] req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [7:0] mean_value, [17:8] out_col, [29:18] out_row
  output logic             m_axis_tlast_o,   // frame_last
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i
);

  localparam int RING   = 2 * MAX_RADIUS + 2;
  localparam int RING_W = $clog2(RING);
  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW     = RING_W + CW;

  state_e state_q, state_d;

  logic [RAD_W-1:0] radius_q;
  logic [10:0]      width_q;
  logic [12:0]      height_q;
  logic [RAD_W-1:0] r_eff;
  logic [10:0]      w_eff;
  logic [12:0]      h_eff;

  logic [CW-1:0]     in_col_q, em_col_q;
  logic [12:0]       in_row_q;
  logic [11:0]       em_row_q;
  logic [RING_W-1:0] in_ring_q, em_ring_q, rd_ring_q, ring0;

  logic [3:0]        dx_q, dy_q, side_m1;
  logic [AREA_W-1:0] area_q;
  logic [SUM_W-1:0]  acc_q;
  logic              rd_vld_q;
  logic [7:0]        rd_data;
  logic [QUO_W-1:0]  mean_q;
  logic              push_done;

  logic        out_vld_q;
  logic [7:0]  out_mean_q;
  logic [9:0]  out_col_q;
  logic [11:0] out_row_q;
  logic        out_last_q;

  logic              in_acc, done_w, pix_wr, rdy, slot_free, load_out, rd_en, push;
  logic              in_col_end, em_col_end, em_row_end, cfg_hit, dx_end, dy_end, y_adv;
  logic [15:0]       ny, nx, hm1, wm1;
  logic signed [15:0] rx, ry0, ryn;
  logic [CW-1:0]     xx;

  // effective configuration
  always_comb begin
    r_eff = (int'(radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_q;
    if (width_q == 11'd0) begin
      w_eff = 11'd1;
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == 13'd0) begin
      h_eff = 13'd1;
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_eff = 13'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  always_comb begin
    hm1 = 16'(h_eff) - 16'd1;
    wm1 = 16'(w_eff) - 16'd1;
    done_w = (in_row_q >= h_eff);
    ny = 16'(em_row_q) + 16'(r_eff);
    if (ny > hm1) ny = hm1;
    nx = 16'(em_col_q) + 16'(r_eff);
    if (nx > wm1) nx = wm1;
    rdy = done_w || (16'(in_row_q) > ny) || ((16'(in_row_q) == ny) && (16'(in_col_q) > nx));
    in_col_end = (16'(in_col_q) + 16'd1 >= 16'(w_eff));
    em_col_end = (16'(em_col_q) + 16'd1 >= 16'(w_eff));
    em_row_end = (16'(em_row_q) + 16'd1 >= 16'(h_eff));
    side_m1 = {r_eff, 1'b0};
    dx_end = (dx_q == side_m1);
    dy_end = (dy_q == side_m1);
    // window column, clamped to the image
    rx = $signed(16'(em_col_q) + 16'(dx_q) - 16'(r_eff));
    if (rx < 0) begin
      xx = '0;
    end else if (rx > $signed(wm1)) begin
      xx = CW'(wm1);
    end else begin
      xx = CW'(rx);
    end
    // the clamped window row moves on only while the next raw row lies inside
    ryn = $signed(16'(em_row_q) + 16'(dy_q) + 16'd1 - 16'(r_eff));
    y_adv = (ryn >= 16'sd1) && (ryn <= $signed(hm1));
    ry0 = $signed(16'(em_row_q) - 16'(r_eff));
    if (ry0 < 0) begin
      ring0 = '0;
    end else if (8'(em_ring_q) >= 8'(r_eff)) begin
      ring0 = RING_W'(8'(em_ring_q) - 8'(r_eff));
    end else begin
      ring0 = RING_W'(8'(em_ring_q) + 8'(RING) - 8'(r_eff));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_axis_tvalid_i) state_d = S_CHECK;
      S_CHECK: state_d = rdy ? S_SUM : S_IDLE;
      S_SUM:   if (dx_end && dy_end) state_d = S_FLUSH;
      S_FLUSH: state_d = S_PUSH;
      S_PUSH:  state_d = S_WAIT;
      S_WAIT:  if (push_done) state_d = S_HOLD;
      S_HOLD:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    push            = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      S_IDLE:  s_axis_tready_o = 1'b1;
      S_SUM:   rd_en = 1'b1;
      S_PUSH:  push = 1'b1;
      S_HOLD:  load_out = slot_free;
      default: ;
    endcase
  end

  assign slot_free = !out_vld_q || m_axis_tready_i;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign pix_wr    = in_acc && !done_w && (s_axis_tuser_i == REQ_PIXEL);
  assign cfg_hit   = cfg_we_i && (cfg_idx_i == CFG_RADIUS || cfg_idx_i == CFG_WIDTH ||
                                  cfg_idx_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(1);
      width_q  <= 11'd1024;
      height_q <= 13'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // input and output positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_ring_q <= '0;
      em_col_q  <= '0;
      em_row_q  <= '0;
      em_ring_q <= '0;
    end else if (cfg_hit || (load_out && em_col_end && em_row_end)) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_ring_q <= '0;
      em_col_q  <= '0;
      em_row_q  <= '0;
      em_ring_q <= '0;
    end else begin
      if (pix_wr) begin
        if (in_col_end) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + 13'd1;
          in_ring_q <= (int'(in_ring_q) == RING - 1) ? '0 : in_ring_q + RING_W'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (load_out) begin
        if (em_col_end) begin
          em_col_q  <= '0;
          em_row_q  <= em_row_q + 12'd1;
          em_ring_q <= (int'(em_ring_q) == RING - 1) ? '0 : em_ring_q + RING_W'(1);
        end else begin
          em_col_q <= em_col_q + CW'(1);
        end
      end
    end
  end

  // window sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CHECK) begin
      dx_q      <= '0;
      dy_q      <= '0;
      rd_ring_q <= ring0;
      acc_q     <= '0;
      area_q    <= AREA_W'(({4'b0, side_m1} + 8'd1) * ({4'b0, side_m1} + 8'd1));
    end else begin
      if (rd_en) begin
        if (dx_end) begin
          dx_q <= '0;
          dy_q <= dy_q + 4'd1;
          if (y_adv) begin
            rd_ring_q <= (int'(rd_ring_q) == RING - 1) ? '0 : rd_ring_q + RING_W'(1);
          end
        end else begin
          dx_q <= dx_q + 4'd1;
        end
      end
      if (rd_vld_q) begin
        acc_q <= acc_q + SUM_W'(rd_data);
      end
    end
  end

  bfm_row_store #(
    .ADDR_W(AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (pix_wr),
    .waddr_i ({in_ring_q, in_col_q}),
    .wdata_i (s_axis_tdata_i),
    .re_i    (rd_en),
    .raddr_i ({rd_ring_q, xx}),
    .rdata_o (rd_data)
  );

  // divider chain: quotient of the window sum by the area, one bit per cell
  logic              c_vld [QUO_W+1];
  logic [AREA_W-1:0] c_rem [QUO_W+1];
  logic [7:0]        c_low [QUO_W+1];
  logic [QUO_W-1:0]  c_quo [QUO_W+1];

  assign c_vld[0] = push;
  assign c_rem[0] = acc_q[SUM_W-1:8];
  assign c_low[0] = acc_q[7:0];
  assign c_quo[0] = '0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    bfm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (c_vld[k]),
      .rem_i  (c_rem[k]),
      .low_i  (c_low[k]),
      .quo_i  (c_quo[k]),
      .area_i (area_q),
      .vld_o  (c_vld[k+1]),
      .rem_o  (c_rem[k+1]),
      .low_o  (c_low[k+1]),
      .quo_o  (c_quo[k+1])
    );
  end

  assign push_done = c_vld[QUO_W];

  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT && push_done) begin
      mean_q <= c_quo[QUO_W];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_mean_q <= mean_q;
      out_col_q  <= 10'(em_col_q);
      out_row_q  <= em_row_q;
      out_last_q <= em_col_end && em_row_end;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_row_q, out_col_q, out_mean_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

### rtl/bfm_checker.sv
// port-level checks for the box filter mean core, bound to the top level
// depends on box_filter_mean_core
`timescale 1ns / 1ps
`default_nettype none

module bfm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // one item at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item accepted while busy");

  // a new result is only loaded while the input side is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared while input open");

  // padding bits of the result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[31:30] == 2'b00)
    else $error("result padding not zero");

endmodule

bind box_filter_mean_core bfm_checker u_bfm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
